@@ rtl/ptenc_pkg.sv @@
package ptenc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW1  = 3'd1,
        PH_LOW2  = 3'd2,
        PH_LOW3  = 3'd3,
        PH_HIGH  = 3'd4,
        PH_PULSE = 3'd5
    } phase_t;

    localparam int ELAPSED_W = 10;
    localparam int PCOUNT_W  = 3;
    localparam int PULSE_W   = 8;
    localparam int CODE_W    = 7;

    localparam logic [ELAPSED_W-1:0] LEN_LOW1       = 10'd440;
    localparam logic [ELAPSED_W-1:0] LEN_LOW23      = 10'd500;
    localparam logic [ELAPSED_W-1:0] LEN_HIGH       = 10'd680;
    localparam logic [ELAPSED_W-1:0] LEN_PULSE_LOW  = 10'd320;
    localparam logic [ELAPSED_W-1:0] LEN_PULSE_HIGH = 10'd660;
    localparam logic [ELAPSED_W-1:0] LEN_PULSE_LAST = 10'd460;

    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_FUNCTION = 1'b1;

    localparam logic [CODE_W-1:0] FUNCTION_RESET = 7'd10;

    typedef struct packed {
        phase_t               phase;
        logic [ELAPSED_W-1:0] elapsed;
        logic [PCOUNT_W-1:0]  preamble_count;
        logic [PULSE_W-1:0]   pulse_count;
        logic                 pulse_level;
        logic [PULSE_W-1:0]   latched_code;
        logic                 pin;
    } ptenc_state_t;

    typedef struct packed {
        logic   pin_level;
        phase_t phase_code;
        logic   frame_end;
    } ptenc_result_t;

endpackage

@@ rtl/ptenc_step.sv @@
module ptenc_step #(
    parameter int PREAMBLE_REPEATS = 4
) (
    input  ptenc_pkg::ptenc_state_t        state,
    input  logic                           tick,
    input  logic                           enable,
    input  logic [ptenc_pkg::CODE_W-1:0]   function_code,
    output ptenc_pkg::ptenc_state_t        state_next,
    output ptenc_pkg::ptenc_result_t       result
);

    logic [ptenc_pkg::ELAPSED_W-1:0] len;
    logic [ptenc_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                            done;
    logic [ptenc_pkg::PCOUNT_W-1:0]  preamble_inc;
    logic [ptenc_pkg::PULSE_W-1:0]   pulse_inc;
    logic                            end_flag;

    assign elapsed_inc  = state.elapsed + 1'b1;
    assign preamble_inc = state.preamble_count + 1'b1;
    assign pulse_inc    = state.pulse_count + 1'b1;

    always_comb
    begin
        case (state.phase)
            ptenc_pkg::PH_LOW1:
            begin
                len = ptenc_pkg::LEN_LOW1;
            end
            ptenc_pkg::PH_LOW2, ptenc_pkg::PH_LOW3:
            begin
                len = ptenc_pkg::LEN_LOW23;
            end
            ptenc_pkg::PH_HIGH:
            begin
                len = ptenc_pkg::LEN_HIGH;
            end
            ptenc_pkg::PH_PULSE:
            begin
                if (!state.pulse_level)
                begin
                    len = ptenc_pkg::LEN_PULSE_LOW;
                end
                else if (pulse_inc == state.latched_code)
                begin
                    len = ptenc_pkg::LEN_PULSE_LAST;
                end
                else
                begin
                    len = ptenc_pkg::LEN_PULSE_HIGH;
                end
            end
            default:
            begin
                len = ptenc_pkg::LEN_LOW1;
            end
        endcase
    end

    assign done = (elapsed_inc >= len);

    always_comb
    begin
        state_next = state;
        end_flag   = 1'b0;
        if (tick)
        begin
            case (state.phase)
                ptenc_pkg::PH_LOW1, ptenc_pkg::PH_LOW2, ptenc_pkg::PH_LOW3:
                begin
                    state_next.pin     = 1'b0;
                    state_next.elapsed = done ? '0 : elapsed_inc;
                    if (done)
                    begin
                        state_next.phase = ptenc_pkg::phase_t'(state.phase + 3'd1);
                    end
                end
                ptenc_pkg::PH_HIGH:
                begin
                    state_next.pin     = 1'b1;
                    state_next.elapsed = done ? '0 : elapsed_inc;
                    if (done)
                    begin
                        state_next.preamble_count = preamble_inc;
                        if (32'(preamble_inc) < PREAMBLE_REPEATS)
                        begin
                            state_next.phase = ptenc_pkg::PH_LOW1;
                        end
                        else
                        begin
                            state_next.phase        = ptenc_pkg::PH_PULSE;
                            state_next.latched_code = {function_code, 1'b0};
                            state_next.pulse_count  = '0;
                            state_next.pulse_level  = 1'b0;
                        end
                    end
                end
                ptenc_pkg::PH_PULSE:
                begin
                    state_next.pin     = state.pulse_level;
                    state_next.elapsed = done ? '0 : elapsed_inc;
                    if (done)
                    begin
                        state_next.pulse_level = ~state.pulse_level;
                        state_next.pulse_count = pulse_inc;
                        if (pulse_inc >= state.latched_code)
                        begin
                            state_next.phase = ptenc_pkg::PH_IDLE;
                            end_flag         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next.phase = ptenc_pkg::PH_IDLE;
                    if (enable)
                    begin
                        state_next.phase          = ptenc_pkg::PH_LOW1;
                        state_next.preamble_count = '0;
                        state_next.elapsed        = '0;
                    end
                end
            endcase
        end
    end

    assign result.pin_level  = state_next.pin;
    assign result.phase_code = state.phase;
    assign result.frame_end  = end_flag;

endmodule

@@ rtl/rc_toy_pulse_train_encoder_unit.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------
// in       | input     | in_valid / in_stall   | tick
// out      | output    | out_valid / out_stall | pin_level, phase_code, frame_end
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each item gives one result item in the cycle after it is taken.
// The throughput is set by the single state update between state and result registers.
// rst_n clears the encoder state and the result valid, and sets the registers (enable 1, code 10).
// in_stall rises only while a result item waits under out_stall.
module rc_toy_pulse_train_encoder_unit #(
    parameter int PREAMBLE_REPEATS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         tick,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         pin_level,
    output logic [2:0]                   phase_code,
    output logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [ptenc_pkg::CODE_W-1:0] cfg_data
);

    ptenc_pkg::ptenc_state_t        state_reg;
    ptenc_pkg::ptenc_state_t        state_next;
    ptenc_pkg::ptenc_result_t       result_reg;
    ptenc_pkg::ptenc_result_t       result_next;
    logic                           out_valid_reg;
    logic                           enable_reg;
    logic [ptenc_pkg::CODE_W-1:0]   function_reg;
    logic                           in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    ptenc_step #(
        .PREAMBLE_REPEATS(PREAMBLE_REPEATS)
    ) u_step (
        .state         (state_reg),
        .tick          (tick),
        .enable        (enable_reg),
        .function_code (function_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            function_reg <= ptenc_pkg::FUNCTION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptenc_pkg::CFG_ENABLE:
                begin
                    enable_reg <= cfg_data[0];
                end
                ptenc_pkg::CFG_FUNCTION:
                begin
                    function_reg <= cfg_data;
                end
                default:
                begin
                    enable_reg <= enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_level  = result_reg.pin_level;
    assign phase_code = result_reg.phase_code;
    assign frame_end  = result_reg.frame_end;

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted item produced no result");

    a_end_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (phase_code == ptenc_pkg::PH_PULSE))
        else $error("frame end outside pulse section");

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == ptenc_pkg::PH_IDLE) |-> (state_reg.elapsed == '0))
        else $error("phase timer running while idle");

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid && frame_end) |-> (state_reg.phase == ptenc_pkg::PH_IDLE))
        else $error("encoder not idle after frame end");
`endif

endmodule
